[rtl/core/ip_reassembly_context_tracker_core_defines.svh]
// Assertion macros shared by the reassembly tracker RTL.
`ifndef IP_REASSEMBLY_CONTEXT_TRACKER_CORE_DEFINES_SVH
`define IP_REASSEMBLY_CONTEXT_TRACKER_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled while rst is high.
`define IRCT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("irct: same-cycle check failed");

// Next-cycle implication, checked on clk and disabled while rst is high.
`define IRCT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("irct: next-cycle check failed");

`endif

[rtl/core/irct_pkg.sv]
package irct_pkg;

  localparam int CONTEXTS     = 8;
  localparam int IDX_W        = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
  localparam int CNT_W        = IDX_W + 1;
  localparam int MAX_RES      = 8;
  localparam int RES_CNT_W    = 4;
  localparam int CTX_RES_W    = 3;
  localparam int LEN_W        = 17;
  localparam int OFFSET_SHIFT = 3;
  localparam logic [LEN_W-1:0] LEN_MAX = 17'h1FFFF;
  localparam logic [7:0] LIFE_RESET    = 8'd60;

  typedef logic [2:0] action_t;
  localparam action_t ACT_PASS     = 3'd0;
  localparam action_t ACT_DROP_DF  = 3'd1;
  localparam action_t ACT_STORED   = 3'd2;
  localparam action_t ACT_COMPLETE = 3'd3;
  localparam action_t ACT_FULL     = 3'd4;
  localparam action_t ACT_EXPIRED  = 3'd5;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  proto;
    logic [15:0] ident;
  } key_t;

  typedef struct packed {
    logic [LEN_W-1:0] bytes;
    logic [LEN_W-1:0] max_end;
    logic             final_seen;
    logic [7:0]       life;
  } ctx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_KSCAN,
    S_RESOLVE,
    S_UPDATE,
    S_TREAD,
    S_TEVAL,
    S_TDONE,
    S_EMIT
  } state_t;

endpackage

[rtl/core/irct_ram.sv]
module irct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             re,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/ip_reassembly_context_tracker_core.sv]
// Channel   Direction  Handshake               Payload
// input     in         in_valid / in_stall     mode, key, offset, flags, length, ttl
// output    out        out_valid / out_stall   action, context_res, datagram_len, last
// config    in         cfg_wr_en               cfg_wr_data (initial lifetime)
//
// A plain header (pass or DF drop) skips the key scan; a fragment's key scan
// walks the key memory read port one entry per cycle.
// A tick reads each context in turn and writes back the aged lifetime of each
// live context that is not yet due; it expires up to MAX_RES due contexts.
// Output stalls hold the block only while a finished result still waits.
// rst is synchronous and active high; it frees every context and sets the
// initial lifetime to 60. No clearing pass is needed.
`include "ip_reassembly_context_tracker_core_defines.svh"

module ip_reassembly_context_tracker_core
  import irct_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [7:0]           cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 mode,
  input  logic [31:0]          src_addr,
  input  logic [31:0]          dst_addr,
  input  logic [7:0]           protocol,
  input  logic [15:0]          ident,
  input  logic [12:0]          frag_offset,
  input  logic                 more_frags,
  input  logic                 dont_frag,
  input  logic [15:0]          payload_len,
  input  logic [7:0]           hop_limit,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           action,
  output logic [CTX_RES_W-1:0] context_res,
  output logic [LEN_W-1:0]     datagram_len,
  output logic                 last
);

  state_t state, state_next;

  // Latched input item.
  logic        q_mode;
  key_t        q_key;
  logic [12:0] q_offset;
  logic        q_more;
  logic        q_df;
  logic [15:0] q_plen;
  logic [7:0]  q_hop;

  logic [7:0]          init_life;
  logic [CONTEXTS-1:0] slot_valid;

  // Key scan bookkeeping.
  logic [CNT_W-1:0] scan_cnt;
  logic             ev_v;
  logic [IDX_W-1:0] ev_idx;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] slot_idx;
  logic             alloc;

  // Tick walk bookkeeping.
  logic [IDX_W-1:0]     walk_idx;
  logic [RES_CNT_W-1:0] exp_cnt;

  // Result held until the output register can take it.
  action_t              res_action;
  logic [CTX_RES_W-1:0] res_ctx;
  logic [LEN_W-1:0]     res_len;
  logic                 res_pend;

  // Memory ports.
  logic             key_we, key_re, ctx_we, ctx_re;
  logic [IDX_W-1:0] key_raddr, ctx_raddr, ctx_waddr;
  key_t             key_rd;
  ctx_t             ctx_rd, ctx_wdata;

  irct_ram #(.WIDTH($bits(key_t)), .DEPTH(CONTEXTS)) u_key_ram (
    .clk     (clk),
    .we      (key_we),
    .wr_addr (slot_idx),
    .wr_data (q_key),
    .re      (key_re),
    .rd_addr (key_raddr),
    .rd_data (key_rd)
  );

  irct_ram #(.WIDTH($bits(ctx_t)), .DEPTH(CONTEXTS)) u_ctx_ram (
    .clk     (clk),
    .we      (ctx_we),
    .wr_addr (ctx_waddr),
    .wr_data (ctx_wdata),
    .re      (ctx_re),
    .rd_addr (ctx_raddr),
    .rd_data (ctx_rd)
  );

  // The output register can take a new transfer when it is empty or its
  // current transfer completes in this cycle.
  logic out_free;
  assign out_free = !out_valid || !out_stall;

  // A packet is a fragment when it has a nonzero offset or more to come.
  logic is_frag;
  assign is_frag = (q_offset != 13'd0) || q_more;

  // Lowest free slot, found straight from the valid flops.
  logic             any_free;
  logic [IDX_W-1:0] free_idx;
  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = CONTEXTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        any_free = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  logic key_eq;
  assign key_eq = (key_rd == q_key);

  // Fragment update of one context. A fresh allocation starts from empty
  // counters and the configured lifetime; the ttl can only raise it.
  ctx_t             base;
  ctx_t             upd;
  logic [LEN_W-1:0] frag_end;
  logic [LEN_W:0]   byte_sum;
  logic             upd_complete;
  always_comb begin
    if (alloc) begin
      base = '{bytes: '0, max_end: '0, final_seen: 1'b0, life: init_life};
    end else begin
      base = ctx_rd;
    end
    frag_end = LEN_W'({q_offset, {OFFSET_SHIFT{1'b0}}}) + LEN_W'(q_plen);
    byte_sum = (LEN_W + 1)'(base.bytes) + (LEN_W + 1)'(q_plen);
    upd.life = (q_hop > base.life) ? q_hop : base.life;
    upd.bytes = (byte_sum > (LEN_W + 1)'(LEN_MAX)) ? LEN_MAX : byte_sum[LEN_W-1:0];
    upd.max_end = (frag_end > base.max_end) ? frag_end : base.max_end;
    upd.final_seen = base.final_seen || !q_more;
    upd_complete = upd.final_seen && (upd.bytes == upd.max_end);
  end

  // Tick decisions for the context just read.
  logic t_valid, t_expire, t_wait, walk_end;
  assign t_valid  = slot_valid[walk_idx];
  assign t_expire = t_valid && (ctx_rd.life == 8'd0) && (exp_cnt < RES_CNT_W'(MAX_RES));
  assign t_wait   = t_expire && res_pend && !out_free;
  assign walk_end = (walk_idx == IDX_W'(CONTEXTS - 1));

  // The output register takes a new transfer in this cycle.
  logic out_load;
  assign out_load = ((state == S_EMIT) && out_free) ||
                    ((state == S_TEVAL) && t_expire && res_pend && !t_wait);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (q_mode) begin
          state_next = S_TREAD;
        end else if (!is_frag || q_df) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_KSCAN;
        end
      end
      S_KSCAN: begin
        if (ev_v && (ev_idx == IDX_W'(CONTEXTS - 1))) begin
          state_next = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        if (hit || any_free) begin
          state_next = S_UPDATE;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_UPDATE: state_next = S_EMIT;
      S_TREAD:  state_next = S_TEVAL;
      S_TEVAL: begin
        if (!t_wait) begin
          state_next = walk_end ? S_TDONE : S_TREAD;
        end
      end
      S_TDONE: state_next = res_pend ? S_EMIT : S_IDLE;
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs: handshake and memory ports.
  always_comb begin
    in_stall  = 1'b1;
    key_re    = 1'b0;
    key_raddr = scan_cnt[IDX_W-1:0];
    key_we    = 1'b0;
    ctx_re    = 1'b0;
    ctx_raddr = walk_idx;
    ctx_we    = 1'b0;
    ctx_waddr = walk_idx;
    ctx_wdata = ctx_rd;
    case (state)
      S_IDLE: in_stall = 1'b0;
      S_KSCAN: key_re = (scan_cnt < CNT_W'(CONTEXTS));
      S_RESOLVE: begin
        ctx_re    = 1'b1;
        ctx_raddr = hit ? hit_idx : free_idx;
      end
      S_UPDATE: begin
        ctx_we    = 1'b1;
        ctx_waddr = slot_idx;
        ctx_wdata = upd;
        key_we    = alloc;
      end
      S_TREAD: ctx_re = 1'b1;
      S_TEVAL: begin
        // A live context that is not yet due loses one tick of lifetime.
        ctx_we         = t_valid && (ctx_rd.life != 8'd0);
        ctx_wdata.life = ctx_rd.life - 8'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      init_life  <= LIFE_RESET;
      slot_valid <= '0;
      out_valid  <= 1'b0;
      res_pend   <= 1'b0;
      ev_v       <= 1'b0;
      hit        <= 1'b0;
      exp_cnt    <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        init_life <= cfg_wr_data;
      end
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            q_mode   <= mode;
            q_key    <= '{src: src_addr, dst: dst_addr, proto: protocol, ident: ident};
            q_offset <= frag_offset;
            q_more   <= more_frags;
            q_df     <= dont_frag;
            q_plen   <= payload_len;
            q_hop    <= hop_limit;
          end
        end
        S_DISPATCH: begin
          scan_cnt <= '0;
          ev_v     <= 1'b0;
          hit      <= 1'b0;
          walk_idx <= '0;
          exp_cnt  <= '0;
          res_pend <= 1'b0;
          res_ctx  <= '0;
          if (!is_frag) begin
            res_action <= ACT_PASS;
            res_len    <= LEN_W'(q_plen);
          end else begin
            res_action <= ACT_DROP_DF;
            res_len    <= '0;
          end
        end
        S_KSCAN: begin
          ev_v     <= key_re;
          ev_idx   <= scan_cnt[IDX_W-1:0];
          scan_cnt <= scan_cnt + CNT_W'(1);
          if (ev_v && slot_valid[ev_idx] && key_eq && !hit) begin
            hit     <= 1'b1;
            hit_idx <= ev_idx;
          end
        end
        S_RESOLVE: begin
          if (hit) begin
            slot_idx <= hit_idx;
            alloc    <= 1'b0;
          end else if (any_free) begin
            slot_idx <= free_idx;
            alloc    <= 1'b1;
          end else begin
            res_action <= ACT_FULL;
            res_ctx    <= '0;
            res_len    <= '0;
          end
        end
        S_UPDATE: begin
          slot_valid[slot_idx] <= !upd_complete;
          res_action <= upd_complete ? ACT_COMPLETE : ACT_STORED;
          res_ctx    <= CTX_RES_W'(slot_idx);
          res_len    <= upd.max_end;
        end
        S_TEVAL: begin
          if (!t_wait) begin
            walk_idx <= walk_idx + IDX_W'(1);
            if (t_expire) begin
              // An earlier expiry goes out now; it cannot be the last one.
              if (res_pend) begin
                out_valid    <= 1'b1;
                action       <= res_action;
                context_res  <= res_ctx;
                datagram_len <= res_len;
                last         <= 1'b0;
              end
              res_action           <= ACT_EXPIRED;
              res_ctx              <= CTX_RES_W'(walk_idx);
              res_len              <= ctx_rd.max_end;
              res_pend             <= 1'b1;
              slot_valid[walk_idx] <= 1'b0;
              exp_cnt              <= exp_cnt + RES_CNT_W'(1);
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            action       <= res_action;
            context_res  <= res_ctx;
            datagram_len <= res_len;
            last         <= 1'b1;
            res_pend     <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  `IRCT_ASSERT_NXT(a_accept_leaves_idle, in_valid && !in_stall, state != S_IDLE)
  `IRCT_ASSERT_IMP(a_idle_no_pending, state == S_IDLE, !res_pend)
  `IRCT_ASSERT_IMP(a_expiry_bound, 1'b1, exp_cnt <= RES_CNT_W'(MAX_RES))
  `IRCT_ASSERT_IMP(a_key_write_on_alloc, key_we, state == S_UPDATE && alloc)
  `IRCT_ASSERT_NXT(a_complete_frees, state == S_UPDATE && upd_complete, !slot_valid[slot_idx])

endmodule

[dv/ip_reassembly_context_tracker_core_tb.sv]
`timescale 1ns / 100ps

module ip_reassembly_context_tracker_core_tb;
  import irct_pkg::*;

  // One item on the input channel. A hold item is not offered until every
  // expected result of the earlier items has arrived.
  typedef struct {
    bit        mode;
    bit [31:0] src;
    bit [31:0] dst;
    bit [7:0]  proto;
    bit [15:0] id;
    bit [12:0] off;
    bit        mf;
    bit        df;
    bit [15:0] plen;
    bit [7:0]  hop;
    bit        hold;
  } frag_item_t;

  // One result transfer on the output channel.
  typedef struct {
    action_t   act;
    bit [2:0]  ctx;
    bit [16:0] len;
    bit        last;
  } verdict_t;

  localparam int NKEYS = 12;

  logic clk = 0;
  logic rst = 1;
  logic cfg_wr_en = 0;
  logic [7:0] cfg_wr_data = 0;
  logic in_valid = 0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 0;
  logic [2:0] action;
  logic [CTX_RES_W-1:0] context_res;
  logic [LEN_W-1:0] datagram_len;
  logic last;

  // The item currently offered; the payload ports follow it.
  frag_item_t cur = '{default: 0};

  frag_item_t pending_items[$];
  verdict_t   expected_verdicts[$];
  int errors = 0;

  // Shadow copy of the context table and of the lifetime register.
  bit        ctx_valid [CONTEXTS];
  bit [31:0] ctx_src   [CONTEXTS];
  bit [31:0] ctx_dst   [CONTEXTS];
  bit [7:0]  ctx_proto [CONTEXTS];
  bit [15:0] ctx_id    [CONTEXTS];
  bit [16:0] ctx_bytes [CONTEXTS];
  bit [16:0] ctx_end   [CONTEXTS];
  bit        ctx_final [CONTEXTS];
  bit [7:0]  ctx_life  [CONTEXTS];
  bit [7:0]  life_cfg = LIFE_RESET;

  // Small key pool so that fragments of different datagrams meet in the table
  // and the table can run full.
  bit [31:0] pool_src   [NKEYS];
  bit [31:0] pool_dst   [NKEYS];
  bit [7:0]  pool_proto [NKEYS];
  bit [15:0] pool_id    [NKEYS];

  ip_reassembly_context_tracker_core uut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(cur.mode), .src_addr(cur.src), .dst_addr(cur.dst),
    .protocol(cur.proto), .ident(cur.id), .frag_offset(cur.off),
    .more_frags(cur.mf), .dont_frag(cur.df), .payload_len(cur.plen),
    .hop_limit(cur.hop),
    .out_valid(out_valid), .out_stall(out_stall),
    .action(action), .context_res(context_res),
    .datagram_len(datagram_len), .last(last)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // Works out the results that one accepted item causes and updates the
  // shadow table the same way the block is expected to.
  function automatic void track_item(frag_item_t it);
    int n;
    int slot;
    bit [16:0] start;
    bit [16:0] fin;
    bit [17:0] sum;
    n = 0;
    slot = -1;
    if (it.mode) begin
      // Tick: expire up to MAX_RES slots whose lifetime ran out, age the ones with time left.
      for (int i = 0; i < CONTEXTS; i++) begin
        if (!ctx_valid[i]) continue;
        if (ctx_life[i] == 0) begin
          if (n < MAX_RES) begin
            ctx_valid[i] = 0;
            expected_verdicts.push_back('{ACT_EXPIRED, i[2:0], ctx_end[i], 1'b0});
            n++;
          end
        end else begin
          ctx_life[i] = ctx_life[i] - 8'd1;
        end
      end
      if (n > 0) expected_verdicts[expected_verdicts.size() - 1].last = 1;
      return;
    end
    start = 17'(it.off) << OFFSET_SHIFT;
    if (start == 0 && !it.mf) begin
      expected_verdicts.push_back('{ACT_PASS, 3'd0, 17'(it.plen), 1'b1});
      return;
    end
    if (it.df) begin
      expected_verdicts.push_back('{ACT_DROP_DF, 3'd0, 17'd0, 1'b1});
      return;
    end
    for (int i = 0; i < CONTEXTS; i++) begin
      if (slot < 0 && ctx_valid[i] && ctx_src[i] == it.src && ctx_dst[i] == it.dst &&
          ctx_proto[i] == it.proto && ctx_id[i] == it.id)
        slot = i;
    end
    if (slot < 0) begin
      for (int i = 0; i < CONTEXTS; i++)
        if (slot < 0 && !ctx_valid[i]) slot = i;
      if (slot < 0) begin
        expected_verdicts.push_back('{ACT_FULL, 3'd0, 17'd0, 1'b1});
        return;
      end
      ctx_valid[slot] = 1;
      ctx_src[slot]   = it.src;
      ctx_dst[slot]   = it.dst;
      ctx_proto[slot] = it.proto;
      ctx_id[slot]    = it.id;
      ctx_bytes[slot] = 0;
      ctx_end[slot]   = 0;
      ctx_final[slot] = 0;
      ctx_life[slot]  = life_cfg;
    end
    if (it.hop > ctx_life[slot]) ctx_life[slot] = it.hop;
    fin = start + 17'(it.plen);
    // The byte count saturates instead of wrapping.
    sum = 18'(ctx_bytes[slot]) + 18'(it.plen);
    ctx_bytes[slot] = (sum > 18'(LEN_MAX)) ? LEN_MAX : sum[16:0];
    if (fin > ctx_end[slot]) ctx_end[slot] = fin;
    if (!it.mf) ctx_final[slot] = 1;
    if (ctx_final[slot] && ctx_bytes[slot] == ctx_end[slot]) begin
      ctx_valid[slot] = 0;
      expected_verdicts.push_back('{ACT_COMPLETE, 3'(slot), ctx_end[slot], 1'b1});
    end else begin
      expected_verdicts.push_back('{ACT_STORED, 3'(slot), ctx_end[slot], 1'b1});
    end
  endfunction

  // Sender: bursts of random length separated by random gaps. The prediction
  // is made at the edge where the transfer happens.
  int burst_left = 4;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) track_item(cur);
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 0;
      end else if (pending_items.size() > 0 &&
                   (!pending_items[0].hold || expected_verdicts.size() == 0)) begin
        cur <= pending_items.pop_front();
        in_valid <= 1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          // Every few bursts the sender runs without gaps for a while.
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 0;
      end
    end
  end

  // Receiver: the stall style is drawn at random, from no stalls at all
  // to long stretches of back pressure.
  int stall_style = 0;
  int cycle_count = 0;

  always @(posedge clk) begin
    verdict_t e;
    cycle_count <= cycle_count + 1;
    if (cycle_count % 64 == 0) stall_style <= $urandom_range(0, 3);
    case (stall_style)
      0: out_stall <= 0;
      1: out_stall <= 1'($urandom_range(0, 1));
      2: out_stall <= ($urandom_range(0, 9) < 8);
      default: out_stall <= (cycle_count % 7) < 3;
    endcase
    if (!rst && out_valid && !out_stall) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected result action=%0d ctx=%0d len=%0d last=%0d",
                 $time, action, context_res, datagram_len, last);
        errors++;
      end else begin
        e = expected_verdicts.pop_front();
        if (action !== e.act) begin
          $display("%0t: action expected %0d actual %0d", $time, e.act, action);
          errors++;
        end
        if (context_res !== e.ctx) begin
          $display("%0t: context_res expected %0d actual %0d", $time, e.ctx, context_res);
          errors++;
        end
        if (datagram_len !== e.len) begin
          $display("%0t: datagram_len expected %0d actual %0d", $time, e.len,
                   datagram_len);
          errors++;
        end
        if (last !== e.last) begin
          $display("%0t: last expected %0d actual %0d", $time, e.last, last);
          errors++;
        end
      end
    end
  end

  function automatic frag_item_t tick_item();
    frag_item_t t;
    t = '{default: 0};
    t.mode = 1;
    return t;
  endfunction

  function automatic frag_item_t header(int k, bit [12:0] off, bit mf, bit [15:0] plen,
                                        bit [7:0] hop);
    frag_item_t h;
    h = '{default: 0};
    h.src = pool_src[k];
    h.dst = pool_dst[k];
    h.proto = pool_proto[k];
    h.id = pool_id[k];
    h.off = off;
    h.mf = mf;
    h.plen = plen;
    h.hop = hop;
    return h;
  endfunction

  // A well-formed datagram from the key pool, cut into fragments on 8-byte
  // boundaries and sent in a shuffled order.
  task automatic add_datagram(output int count);
    frag_item_t frags[$];
    frag_item_t t;
    int k;
    int nfr;
    int units;
    int j;
    k = $urandom_range(0, NKEYS - 1);
    nfr = $urandom_range(2, 4);
    units = 0;
    for (int i = 0; i < nfr; i++) begin
      if (i == nfr - 1) begin
        frags.push_back(header(k, 13'(units), 0, 16'($urandom_range(1, 200)),
                               8'($urandom_range(0, 4))));
      end else begin
        j = $urandom_range(1, 20);
        frags.push_back(header(k, 13'(units), 1, 16'(j * 8),
                               8'($urandom_range(0, 4))));
        units += j;
      end
    end
    for (int i = nfr - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = frags[i];
      frags[i] = frags[j];
      frags[j] = t;
    end
    // Now and then a fragment is lost, which leaves the context to expire.
    if ($urandom_range(0, 5) == 0) void'(frags.pop_back());
    count = frags.size();
    foreach (frags[i]) pending_items.push_back(frags[i]);
  endtask

  // Any bit pattern at all, with a fair share of ticks.
  function automatic frag_item_t noise_item();
    frag_item_t n;
    n = '{default: 0};
    n.mode = ($urandom_range(0, 3) == 0);
    n.src = $urandom;
    n.dst = $urandom;
    n.proto = 8'($urandom);
    n.id = 16'($urandom);
    n.off = 13'($urandom);
    n.mf = 1'($urandom);
    n.df = 1'($urandom);
    n.plen = 16'($urandom);
    n.hop = 8'($urandom);
    return n;
  endfunction

  task automatic write_lifetime(bit [7:0] v);
    @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
    life_cfg = v;
  endtask

  // Waits until every item went out and every result came back, then lets a
  // tick that produces no result finish before anything else happens.
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() > 0 || in_valid || expected_verdicts.size() > 0);
    repeat (2 * CONTEXTS + 12) @(posedge clk);
  endtask

  initial begin
    frag_item_t h;
    int sent;
    int cnt;
    int pick;
    bit [7:0] phase_life [6];

    phase_life = '{8'd0, 8'd255, 8'd1, 8'd60, 8'd2, 8'd3};
    foreach (ctx_valid[i]) ctx_valid[i] = 0;
    for (int k = 0; k < NKEYS; k++) begin
      pool_src[k] = $urandom;
      pool_dst[k] = $urandom;
      pool_proto[k] = 8'($urandom);
      pool_id[k] = 16'($urandom);
    end
    repeat (12) @(posedge clk);
    rst <= 0;

    // Directed part, with a lifetime of zero so that a tick expires every context
    // whose lifetime no fragment's ttl raised.
    write_lifetime(8'd0);
    pending_items.push_back(header(0, 0, 0, 16'hFFFF, 8'hFF));  // unfragmented
    h = header(1, 13'd5, 1, 16'd64, 0);
    h.df = 1;
    pending_items.push_back(h);                                 // DF fragment
    h = '{default: 0};
    h.src = '1; h.dst = '1; h.proto = '1; h.id = '1; h.off = '1; h.mf = 1;
    h.plen = '1; h.hop = '1;
    pending_items.push_back(h);                                 // all ones
    h.mf = 0; h.plen = 0; h.hop = 0; h.off = 1;
    pending_items.push_back(h);                                 // final after max end
    // Byte count saturation: three full-size fragments on one key.
    for (int i = 0; i < 3; i++) pending_items.push_back(header(2, 13'(i), 1, '1, 1));
    // Two fragments that complete a datagram out of order.
    pending_items.push_back(header(3, 13'd2, 0, 16'd10, 0));
    pending_items.push_back(header(3, 13'd0, 1, 16'd16, 0));
    // Fill the table and overflow it.
    for (int k = 4; k < NKEYS; k++) pending_items.push_back(header(k, 13'd1, 1, 16'd8, 0));
    pending_items.push_back(tick_item());
    pending_items.push_back(tick_item());
    pending_items.push_back(tick_item());
    wait_idle();

    // Random phases, each under its own lifetime setting.
    foreach (phase_life[p]) begin
      write_lifetime(p == 5 ? 8'($urandom_range(0, 255)) : phase_life[p]);
      sent = 0;
      while (sent < 50) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          add_datagram(cnt);
          sent += cnt;
        end else if (pick < 85) begin
          pending_items.push_back(tick_item());
          sent++;
        end else begin
          pending_items.push_back(noise_item());
          sent++;
        end
        // Once in a while the sender waits for every result to come back.
        if (sent > 20 && sent < 25 && pending_items.size() > 0)
          pending_items[pending_items.size() - 1].hold = 1;
      end
      // Flush the table so the next phase starts from lifetimes it controls.
      for (int i = 0; i < 3; i++) pending_items.push_back(tick_item());
      if (p == 0)
        repeat (phase_life[p] + 1) pending_items.push_back(tick_item());
      wait_idle();
    end

    if (errors == 0 && expected_verdicts.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/irct_pkg.sv
rtl/core/irct_ram.sv
rtl/core/ip_reassembly_context_tracker_core.sv
dv/ip_reassembly_context_tracker_core_tb.sv
